[design/luhn_card_number_classifier_assert.svh]
// assertion macros used by the controller
`ifndef LUHN_CARD_NUMBER_CLASSIFIER_ASSERT_SVH
`define LUHN_CARD_NUMBER_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define LUHN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LUHN_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/luhn_pkg.sv]
`timescale 1ns / 1ps

package luhn_pkg;

    localparam int CARD_W          = 63;
    localparam int BITS_PER_STEP   = 4;
    localparam int CONV_STEPS      = 16;
    localparam int BIN_W           = CONV_STEPS * BITS_PER_STEP;
    localparam int BCD_DIGITS      = 20;
    localparam int BCD_W           = BCD_DIGITS * 4;
    localparam int DIGITS_PER_SCAN = 4;
    localparam int SCAN_STEPS      = BCD_DIGITS / DIGITS_PER_SCAN;
    localparam int SCAN_IDX_W      = 3;
    localparam int STEP_CNT_W      = 4;
    localparam int SUM_W           = 8;
    localparam int CNT_W           = 5;
    localparam int CLS_W           = 2;
    localparam int MAX_SUM_TENS    = 18;

    localparam logic [CLS_W-1:0] CLS_INVALID = 2'd0;
    localparam logic [CLS_W-1:0] CLS_PFX_3X  = 2'd1;
    localparam logic [CLS_W-1:0] CLS_PFX_4   = 2'd2;
    localparam logic [CLS_W-1:0] CLS_PFX_5X  = 2'd3;

    typedef struct packed {
        logic                  load;
        logic                  conv;
        logic                  scan;
        logic [SCAN_IDX_W-1:0] scan_idx;
        logic                  emit;
    } t_cmd;

    // one double-dabble bit: add 3 to digits of 5 or more, then shift in
    function automatic logic [BCD_W-1:0] dabble_bit(input logic [BCD_W-1:0] bcd,
                                                    input logic             bit_in);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int d = 0; d < BCD_DIGITS; d++) begin
            if (bcd[d*4 +: 4] >= 4'd5) begin
                adj[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

    // doubled digit with its two decimal digits added
    function automatic logic [3:0] luhn_dbl(input logic [3:0] d);
        logic [4:0] p;
        p = {d, 1'b0};
        if (p >= 5'd10) begin
            return 4'(p - 5'd9);
        end
        return p[3:0];
    endfunction

    function automatic logic is_mult10(input logic [SUM_W-1:0] s);
        logic hit;
        hit = 1'b0;
        for (int m = 0; m <= MAX_SUM_TENS; m++) begin
            if (s == SUM_W'(m * 10)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

[design/luhn_datapath.sv]
`timescale 1ns / 1ps

module luhn_datapath (
    input  logic                            i_clk,
    input  luhn_pkg::t_cmd                  i_cmd,
    input  logic [luhn_pkg::CARD_W-1:0]     i_card_number,
    output logic [luhn_pkg::CLS_W-1:0]      o_issuer_class,
    output logic                            o_checksum_ok,
    output logic [luhn_pkg::CNT_W-1:0]      o_digit_count
);
    import luhn_pkg::*;

    logic [BIN_W-1:0] r_bin, n_bin;
    logic [BCD_W-1:0] r_bcd, n_bcd;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0] r_count, n_count;
    logic [3:0]       r_lead_hi, n_lead_hi;
    logic [3:0]       r_lead_lo, n_lead_lo;
    logic [3:0]       r_prev_top, n_prev_top;
    logic [CLS_W-1:0] r_cls, n_cls;
    logic             r_ok;
    logic [CNT_W-1:0] r_dcnt;

    logic [3:0]       dig [0:DIGITS_PER_SCAN];
    logic [CNT_W-1:0] base;

    always_comb begin
        for (int k = 0; k < DIGITS_PER_SCAN; k++) begin
            dig[k+1] = r_bcd[k*4 +: 4];
        end
        dig[0] = r_prev_top;
        base   = {r_lead_hi[0] & 1'b0, i_cmd.scan_idx, 1'b0} << 1;
    end

    always_comb begin
        n_bin      = r_bin;
        n_bcd      = r_bcd;
        n_sum      = r_sum;
        n_count    = r_count;
        n_lead_hi  = r_lead_hi;
        n_lead_lo  = r_lead_lo;
        n_prev_top = r_prev_top;
        if (i_cmd.load) begin
            n_bin      = {{(BIN_W-CARD_W){1'b0}}, i_card_number};
            n_bcd      = '0;
            n_sum      = '0;
            n_count    = '0;
            n_lead_hi  = '0;
            n_lead_lo  = '0;
            n_prev_top = '0;
        end else if (i_cmd.conv) begin
            for (int b = 0; b < BITS_PER_STEP; b++) begin
                n_bcd = dabble_bit(n_bcd, n_bin[BIN_W-1]);
                n_bin = {n_bin[BIN_W-2:0], 1'b0};
            end
        end else if (i_cmd.scan) begin
            // odd places from the right add as is, even places doubled
            n_sum = r_sum + SUM_W'(dig[1]) + SUM_W'(luhn_dbl(dig[2]))
                          + SUM_W'(dig[3]) + SUM_W'(luhn_dbl(dig[4]));
            for (int k = 0; k < DIGITS_PER_SCAN; k++) begin
                if (dig[k+1] != 4'd0) begin
                    n_count   = base + CNT_W'(k + 1);
                    n_lead_hi = dig[k+1];
                    n_lead_lo = dig[k];
                end
            end
            n_prev_top = dig[DIGITS_PER_SCAN];
            n_bcd      = r_bcd >> (DIGITS_PER_SCAN * 4);
        end
    end

    always_comb begin
        n_cls = CLS_INVALID;
        if (r_count >= CNT_W'(2)) begin
            if (r_lead_hi == 4'd3 && (r_lead_lo == 4'd4 || r_lead_lo == 4'd7)) begin
                if (r_count == CNT_W'(15)) begin
                    n_cls = CLS_PFX_3X;
                end
            end else if (r_lead_hi == 4'd4) begin
                if (r_count == CNT_W'(13) || r_count == CNT_W'(16)) begin
                    n_cls = CLS_PFX_4;
                end
            end else if (r_lead_hi == 4'd5 && r_lead_lo >= 4'd1 && r_lead_lo <= 4'd5) begin
                if (r_count == CNT_W'(16)) begin
                    n_cls = CLS_PFX_5X;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin      <= n_bin;
        r_bcd      <= n_bcd;
        r_sum      <= n_sum;
        r_count    <= n_count;
        r_lead_hi  <= n_lead_hi;
        r_lead_lo  <= n_lead_lo;
        r_prev_top <= n_prev_top;
        if (i_cmd.emit) begin
            r_cls  <= n_cls;
            r_ok   <= is_mult10(r_sum);
            r_dcnt <= r_count;
        end
    end

    assign o_issuer_class = r_cls;
    assign o_checksum_ok  = r_ok;
    assign o_digit_count  = r_dcnt;

endmodule

[design/luhn_ctrl.sv]
`timescale 1ns / 1ps

`include "luhn_card_number_classifier_assert.svh"

module luhn_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    output luhn_pkg::t_cmd o_cmd
);
    import luhn_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_LOAD = 2'd3;

    localparam logic [STEP_CNT_W-1:0] CONV_LAST = STEP_CNT_W'(CONV_STEPS - 1);
    localparam logic [STEP_CNT_W-1:0] SCAN_LAST = STEP_CNT_W'(SCAN_STEPS - 1);

    logic [1:0]            r_state, n_state;
    logic [STEP_CNT_W-1:0] r_cnt, n_cnt;
    logic                  r_valid, n_valid;
    logic                  accept;
    logic                  emit;

    assign accept = i_valid && (r_state == ST_IDLE);
    assign emit   = (r_state == ST_LOAD) && (!r_valid || !i_stall);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_CONV;
                    n_cnt   = '0;
                end
            end
            ST_CONV: begin
                if (r_cnt == CONV_LAST) begin
                    n_state = ST_SCAN;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_SCAN: begin
                if (r_cnt == SCAN_LAST) begin
                    n_state = ST_LOAD;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_LOAD: begin
                if (emit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (emit) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = accept;
        o_cmd.conv     = (r_state == ST_CONV);
        o_cmd.scan     = (r_state == ST_SCAN);
        o_cmd.scan_idx = r_cnt[SCAN_IDX_W-1:0];
        o_cmd.emit     = emit;
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_valid;

    `LUHN_ASSERT_NXT(a_accept_starts, accept, r_state == ST_CONV && r_cnt == '0,
        "accepted beat did not start conversion")
    `LUHN_ASSERT_NXT(a_scan_to_load, r_state == ST_SCAN && r_cnt == SCAN_LAST,
        r_state == ST_LOAD, "scan did not finish into load")
    `LUHN_ASSERT_NXT(a_emit_shows, emit, r_valid, "emitted result not presented")
    `LUHN_ASSERT_IMP(a_no_overwrite, r_valid && i_stall, !emit,
        "result overwritten while stalled")

endmodule

[design/luhn_card_number_classifier.sv]
`timescale 1ns / 1ps

// channel | valid   | stall   | payload
// --------+---------+---------+----------------------------------------------
// in      | i_valid | o_stall | i_card_number
// out     | o_valid | i_stall | o_issuer_class, o_checksum_ok, o_digit_count
//
// the result is registered after 16 binary to bcd steps at 4 bits each,
// 5 digit scan steps at 4 digits each, and one to classify
// the next input beat can be taken in the cycle after the result is registered
// the output register lets the next input beat in while a result waits
// reset is synchronous and clears the controller and output valid
module luhn_card_number_classifier (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [luhn_pkg::CARD_W-1:0] i_card_number,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [luhn_pkg::CLS_W-1:0]  o_issuer_class,
    output logic                        o_checksum_ok,
    output logic [luhn_pkg::CNT_W-1:0]  o_digit_count
);
    import luhn_pkg::*;

    t_cmd cmd;

    luhn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    luhn_datapath u_datapath (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .i_card_number  (i_card_number),
        .o_issuer_class (o_issuer_class),
        .o_checksum_ok  (o_checksum_ok),
        .o_digit_count  (o_digit_count)
    );

endmodule
